// ===== rtl/salru_pkg.sv =====
// Package: shared constants for the LRU tag lookup block.
`timescale 1ns / 1ps
`default_nettype none
package salru_pkg;
  localparam int CFG_W = 4;
  localparam logic [1:0] REG_OFS_W = 2'd0;
  localparam logic [1:0] REG_IDX_W = 2'd1;
  localparam logic [1:0] REG_WAYS  = 2'd2;
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/salru_front.sv =====
// Front end: accepts accesses, splits the address into set and tag, queues them.
`timescale 1ns / 1ps
`default_nettype none
module salru_front import salru_pkg::*; #(
  parameter int ADDR_BITS = 24,
  parameter int SET_BITS  = 10,
  parameter int QDEPTH_LOG = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 cmd,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic [CFG_W-1:0]     ofs_w,
  input  wire logic [CFG_W-1:0]     idx_w,
  input  wire logic                 q_pop,
  output logic                      q_valid,
  output logic                      q_cmd,
  output logic [SET_BITS-1:0]       q_set,
  output logic [ADDR_BITS-1:0]      q_tag
);
  localparam int QD = 1 << QDEPTH_LOG;
  localparam int EW = 1 + SET_BITS + ADDR_BITS;

  logic [EW-1:0] q_mem_r [QD];
  logic [QDEPTH_LOG:0] wp_r, rp_r;
  logic [CFG_W-1:0] ib;
  logic [ADDR_BITS-1:0] sh, set_mask;
  logic [ADDR_BITS-1:0] tag;
  logic [SET_BITS-1:0] set;
  logic [5:0] tsh;

  // Clamp index width to what the set RAM holds.
  always_comb begin
    ib = (6'(idx_w) > 6'(SET_BITS)) ? CFG_W'(SET_BITS) : idx_w;
    sh = address >> ofs_w;
    set_mask = (ADDR_BITS'(1) << ib) - ADDR_BITS'(1);
    set = SET_BITS'(sh & set_mask);
    tsh = 6'(ofs_w) + 6'(ib);
    tag = (tsh >= 6'(ADDR_BITS)) ? '0 : (address >> tsh);
  end

  assign full = (wp_r[QDEPTH_LOG] != rp_r[QDEPTH_LOG]) &&
                (wp_r[QDEPTH_LOG-1:0] == rp_r[QDEPTH_LOG-1:0]);
  assign q_valid = (wp_r != rp_r);
  assign {q_cmd, q_set, q_tag} = q_mem_r[rp_r[QDEPTH_LOG-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) q_mem_r[wp_r[QDEPTH_LOG-1:0]] <= {cmd, set, tag};
  end
endmodule
`default_nettype wire

// ===== rtl/salru_back.sv =====
// Back end: clears the set RAM, then reads, compares and updates one set per access.
`timescale 1ns / 1ps
`default_nettype none
module salru_back import salru_pkg::*; #(
  parameter int ADDR_BITS = 24,
  parameter int SET_BITS  = 10,
  parameter int MAX_WAYS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CFG_W-1:0]     ways,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire logic                 q_cmd,
  input  wire logic [SET_BITS-1:0]  q_set,
  input  wire logic [ADDR_BITS-1:0] q_tag,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      hit
);
  localparam int NSETS = 1 << SET_BITS;
  localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WI = $clog2(MAX_WAYS + 1);
  localparam int EW = ADDR_BITS + 1 + RW;
  localparam int LW = MAX_WAYS * EW;
  localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_WR   = 2'd3;

  logic [LW-1:0] ram [NSETS];
  logic [LW-1:0] rd_r, wdata;
  logic [1:0] st_r;
  logic [SET_BITS-1:0] clr_r, set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic cmd_r, ovalid_r, hit_nxt, ohit_r;
  logic [WI-1:0] nw;

  always_comb begin
    if (ways == '0) nw = WI'(1);
    else if ({1'b0, ways} > (CFG_W+1)'(MAX_WAYS)) nw = WI'(MAX_WAYS);
    else nw = WI'(ways);
  end

  // Compare and build the updated set line.
  always_comb begin
    logic [ADDR_BITS-1:0] t [MAX_WAYS];
    logic v [MAX_WAYS];
    logic [RW-1:0] r [MAX_WAYS];
    logic found, have_empty, act;
    logic [WI-1:0] hw, ew, vw, tgt;
    logic [RW-1:0] hr;
    found = 1'b0; have_empty = 1'b0; hw = '0; ew = '0; vw = '0; hr = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      {t[w], v[w], r[w]} = rd_r[w*EW +: EW];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WI'(w) < nw) begin
        if (v[w] && t[w] == tag_r) begin found = 1'b1; hw = WI'(w); hr = r[w]; end
        if (!v[w]) begin have_empty = 1'b1; ew = WI'(w); end
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WI'(w) < nw && r[w] > r[vw[RW-1:0]]) vw = WI'(w);
    end
    tgt = found ? hw : (have_empty ? ew : vw);
    act = found || (cmd_r == CMD_LOAD);
    wdata = rd_r;
    hit_nxt = found;
    if (act) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (WI'(w) < nw && WI'(w) != tgt && v[w] && (!found || r[w] < hr)
            && r[w] < RMAX)
          wdata[w*EW +: EW] = {t[w], v[w], r[w] + RW'(1)};
      end
      wdata[tgt[RW-1:0]*EW +: EW] = {tag_r, 1'b1, RW'(0)};
    end
  end

  assign q_pop = (st_r == ST_IDLE) && !ovalid_r;
  assign empty = !ovalid_r;
  assign hit = ohit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop && ovalid_r) ovalid_r <= 1'b0;
      case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_BITS'(NSETS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: if (q_valid && !ovalid_r) st_r <= ST_RD;
        ST_RD: st_r <= ST_WR;
        ST_WR: begin
          ovalid_r <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      set_r <= q_set; tag_r <= q_tag; cmd_r <= q_cmd;
    end
    if (st_r == ST_WR) ohit_r <= hit_nxt;
  end

  // Set RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (st_r == ST_CLR) ram[clr_r] <= '0;
    else if (st_r == ST_WR) ram[set_r] <= wdata;
    rd_r <= ram[set_r];
  end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_lru_tag_lookup_top.sv =====
// Top level of the set-associative LRU tag lookup block.
//  channel | ports                         | handshake
//  input   | in_cmd, in_address            | push / full
//  result  | out_hit                       | pop / empty
//  config  | cfg_we, cfg_index, cfg_data   | write enable, no wait
// A transaction's result is built after acceptance by queue pop, set RAM
// read, then compare and write back into the result register. The back end
// starts no new transaction until the result register has emptied, and the
// set RAM read-modify-write also limits the rate. After reset a clearing
// pass over every set RAM line runs before the first access proceeds;
// inputs queue meanwhile. A stalled result holds the back end; the front
// queue keeps taking transactions until full.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_tag_lookup_top import salru_pkg::*; #(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 in_cmd,
  input  wire logic [ADDR_BITS-1:0] in_address,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      out_hit,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);
  localparam int SET_BITS = (MAX_SETS > 1) ? $clog2(MAX_SETS + 1) - 1 : 1;

  logic [CFG_W-1:0] ofs_w_r, idx_w_r, ways_r, ib_eff;
  logic q_valid, q_pop, q_cmd;
  logic [SET_BITS-1:0] q_set;
  logic [ADDR_BITS-1:0] q_tag;

  // Hold configuration; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_w_r <= CFG_W'(5);
      idx_w_r <= CFG_W'(6);
      ways_r  <= CFG_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFS_W: ofs_w_r <= cfg_data;
        REG_IDX_W: idx_w_r <= cfg_data;
        REG_WAYS:  ways_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A single set uses no index bits at all.
  assign ib_eff = (MAX_SETS > 1) ? idx_w_r : '0;

  salru_front #(.ADDR_BITS(ADDR_BITS), .SET_BITS(SET_BITS), .QDEPTH_LOG(1)) u_front (
    .clk, .rst_n, .push, .full, .cmd(in_cmd), .address(in_address),
    .ofs_w(ofs_w_r), .idx_w(ib_eff),
    .q_pop, .q_valid, .q_cmd, .q_set, .q_tag
  );

  salru_back #(.ADDR_BITS(ADDR_BITS), .SET_BITS(SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk, .rst_n, .ways(ways_r), .q_valid, .q_pop, .q_cmd, .q_set, .q_tag,
    .empty, .pop, .hit(out_hit)
  );
endmodule
`default_nettype wire

// ===== rtl/salru_checker.sv =====
// Port-level checker for the LRU tag lookup block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module salru_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire logic out_hit
);
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");
  a_not_full_after_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("queue full after reset");
  a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_hit)))
    else $error("waiting result changed");
  a_no_result_without_input: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty)
    else $error("result without transaction");
endmodule
bind set_assoc_lru_tag_lookup_top salru_checker u_salru_checker (
  .clk, .rst_n, .full, .empty, .pop, .out_hit
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the set-associative LRU tag lookup: directed and random accesses.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import salru_pkg::*;

  localparam int N_SETS    = 1024;
  localparam int N_WAYS    = 8;
  localparam int A_BITS    = 24;
  localparam int IDX_LIM   = 10;             // floor(log2(N_SETS))
  localparam int CYC_LIMIT = 2_000_000;
  localparam int DRAIN_CYC = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_cmd = 1'b0;
  logic [A_BITS-1:0] in_address = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_hit;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  set_assoc_lru_tag_lookup_top #(
    .MAX_SETS(N_SETS), .MAX_WAYS(N_WAYS), .ADDR_BITS(A_BITS)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .in_address(in_address), .empty(empty), .pop(pop), .out_hit(out_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow tag store, one flat entry per set and way.
  logic [A_BITS-1:0] tag_mirror [N_SETS*N_WAYS];
  logic              valid_mirror [N_SETS*N_WAYS];
  logic [2:0]        rank_mirror [N_SETS*N_WAYS];
  logic [3:0]        offset_sh = 4'd5;
  logic [3:0]        index_sh = 4'd6;
  logic [3:0]        ways_sh = 4'd4;

  logic              hit_queue [$];
  int                mismatches = 0;
  int                cycles = 0;
  bit                idle_on = 1'b1;   // enables random gaps on both sides
  int                hot_tags [8];     // small tag pool to provoke hits

  // Bump age of a way, saturating at the oldest rank.
  function automatic void age_way(int e);
    if (rank_mirror[e] < 3'(N_WAYS - 1)) rank_mirror[e] = rank_mirror[e] + 3'd1;
  endfunction

  // Look up one access in the shadow store, update LRU state, return hit.
  function automatic logic lookup_access(logic cmd, logic [A_BITS-1:0] addr);
    int ib, nw, set_no, base, hw, victim;
    logic [A_BITS-1:0] tg;
    logic [2:0] r;
    ib = (index_sh > IDX_LIM) ? IDX_LIM : int'(index_sh);
    nw = (ways_sh == 0) ? 1 : (ways_sh > N_WAYS) ? N_WAYS : int'(ways_sh);
    set_no = int'((addr >> offset_sh) & ((24'd1 << ib) - 24'd1));
    tg = addr >> (int'(offset_sh) + ib);
    base = set_no * N_WAYS;
    hw = -1;
    for (int w = 0; w < nw; w++)
      if (hw < 0 && valid_mirror[base+w] && tag_mirror[base+w] == tg) hw = w;
    if (hw >= 0) begin
      r = rank_mirror[base+hw];
      for (int w = 0; w < nw; w++)
        if (valid_mirror[base+w] && w != hw && rank_mirror[base+w] < r) age_way(base+w);
      rank_mirror[base+hw] = '0;
    end else if (cmd == CMD_LOAD) begin
      victim = nw;
      for (int w = 0; w < nw; w++)
        if (victim == nw && !valid_mirror[base+w]) victim = w;
      if (victim == nw) begin
        victim = 0;
        for (int w = 1; w < nw; w++)
          if (rank_mirror[base+w] > rank_mirror[base+victim]) victim = w;
      end
      for (int w = 0; w < nw; w++)
        if (w != victim && valid_mirror[base+w]) age_way(base+w);
      tag_mirror[base+victim] = tg;
      valid_mirror[base+victim] = 1'b1;
      rank_mirror[base+victim] = '0;
    end
    return hw >= 0;
  endfunction

  // Send one transaction; predict at acceptance. Optional random gap first.
  task automatic send_access(logic cmd, logic [A_BITS-1:0] addr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    push <= 1'b1;
    in_cmd <= cmd;
    in_address <= addr;
    do @(posedge clk); while (full);
    hit_queue.push_back(lookup_access(cmd, addr));
    @(negedge clk);
  endtask

  // Drop push and wait until every expected result has arrived.
  task automatic drain_results();
    push <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Write one register; only called while idle.
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OFS_W) offset_sh = val;
    else if (idx == REG_IDX_W) index_sh = val;
    else if (idx == REG_WAYS) ways_sh = val;
  endtask

  task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
    drain_results();
    write_reg(REG_OFS_W, ob);
    write_reg(REG_IDX_W, ib);
    write_reg(REG_WAYS, nw);
  endtask

  // Build an address from a tag number, set and offset under current geometry.
  function automatic logic [A_BITS-1:0] make_addr(int tg, int set_no, int off);
    int ib;
    ib = (index_sh > IDX_LIM) ? IDX_LIM : int'(index_sh);
    return A_BITS'((longint'(tg) << (int'(offset_sh) + ib)) |
                   (longint'(set_no & ((1 << ib) - 1)) << offset_sh) |
                   (off & ((1 << offset_sh) - 1)));
  endfunction

  // Directed: extremes, both commands, LRU eviction, store miss, odd registers.
  task automatic test_directed();
    send_access(CMD_LOAD, '0);
    send_access(CMD_LOAD, '0);
    send_access(CMD_STORE, '1);
    send_access(CMD_LOAD, '1);
    send_access(CMD_STORE, '1);
    // Fill set 3 past its four ways, revisit tag 2 in way 1, then evict the oldest.
    for (int t = 1; t <= 5; t++) send_access(CMD_LOAD, make_addr(t, 3, 0));
    send_access(CMD_LOAD, make_addr(2, 3, 7));
    send_access(CMD_LOAD, make_addr(1, 3, 0));
    send_access(CMD_STORE, make_addr(9, 3, 0));
    send_access(CMD_LOAD, make_addr(9, 3, 0));
    // Unknown register index leaves settings alone.
    drain_results();
    write_reg(2'd3, 4'hF);
    // Too many index bits and zero ways; entries survive the change.
    set_geometry(4'd0, 4'd15, 4'd0);
    send_access(CMD_LOAD, 24'h00_0003);
    send_access(CMD_LOAD, 24'h00_0403);
    send_access(CMD_LOAD, 24'h00_0003);
    set_geometry(4'd10, 4'd0, 4'd15);
    for (int t = 0; t < 10; t++) send_access(CMD_LOAD, make_addr(t % 9, 0, t));
  endtask

  // Random phase under one geometry, mostly reusing a small pool of tags.
  task automatic test_random_phase(int n);
    logic [A_BITS-1:0] a;
    for (int k = 0; k < 8; k++) hot_tags[k] = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        a = make_addr(hot_tags[$urandom_range(0, 7)] & 'hF, $urandom_range(0, 3),
                      $urandom());
      else
        a = A_BITS'($urandom());
      send_access(logic'($urandom_range(0, 3) == 0), a);
    end
  endtask

  task automatic test_random();
    set_geometry(4'd5, 4'd6, 4'd4);
    test_random_phase(200);
    set_geometry(4'd2, 4'd2, 4'd8);
    test_random_phase(200);
    set_geometry(4'd0, 4'd10, 4'd1);
    test_random_phase(200);
    set_geometry(4'd10, 4'd0, 4'd8);
    test_random_phase(200);
    set_geometry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)));
    test_random_phase(200);
    // Last stretch: no gaps on either side.
    set_geometry(4'd3, 4'd1, 4'd3);
    idle_on = 1'b0;
    test_random_phase(200);
  endtask

  // Result side: random pop bursts; compare each accepted result in order.
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && pop && !empty) begin
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit=%0b", out_hit);
      end else begin
        logic exp_hit;
        exp_hit = hit_queue.pop_front();
        if (out_hit !== exp_hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hit mismatch: expected %0b, actual %0b", exp_hit, out_hit);
        end
      end
    end
  end

  // Cycle limit covers the post-reset clearing pass and worst stalls.
  always @(posedge clk)
    if (cycles >= CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  initial begin
    for (int e = 0; e < N_SETS*N_WAYS; e++) begin
      tag_mirror[e] = '0;
      valid_mirror[e] = 1'b0;
      rank_mirror[e] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    drain_results();
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/salru_pkg.sv
rtl/salru_front.sv
rtl/salru_back.sv
rtl/set_assoc_lru_tag_lookup_top.sv
rtl/salru_checker.sv
sim/testbench.sv
